>>> hdl/count_to_freq_and_period_digits_unit_macros.svh
// Assertion macros for the frequency and period digit unit.
`ifndef COUNT_TO_FREQ_AND_PERIOD_DIGITS_UNIT_MACROS_SVH
`define COUNT_TO_FREQ_AND_PERIOD_DIGITS_UNIT_MACROS_SVH
`ifndef SYNTH
`define CFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CFP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/cfpd_pkg.sv
// Shared types and constants for the frequency and period digit unit.
`default_nettype none
package cfpd_pkg;
    localparam int unsigned USEC_THRESHOLD = 1000;
    localparam int unsigned USEC_NUMERATOR = 1000000;
    localparam int unsigned NSEC_NUMERATOR = 1000000000;
    localparam int unsigned NUM_BITS = 30;
    // Side information carried down the chain with each request.
    typedef struct packed {
        logic fover;
        logic unit;
        logic zero;
    } t_flags;
endpackage
`default_nettype wire

>>> hdl/cfpd_div_cell.sv
// One restoring division cell: settles one quotient bit per stage.
`default_nettype none
module cfpd_div_cell #(
    parameter int TW = 24,
    parameter int NB = 30,
    parameter int BIT = 0,
    parameter int VW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_stall,
    input  wire logic [NB-1:0] i_rem,
    input  wire logic [TW-1:0] i_den,
    input  wire logic [NB-1:0] i_quo,
    input  wire logic [VW-1:0] i_side,
    output logic               o_valid,
    output logic [NB-1:0]      o_rem,
    output logic [TW-1:0]      o_den,
    output logic [NB-1:0]      o_quo,
    output logic [VW-1:0]      o_side
);
    logic [NB+TW-1:0] w_shd;
    logic             w_ge;
    logic [NB-1:0]    n_rem;
    logic [NB-1:0]    n_quo;

    always_comb begin
        w_shd = {{NB{1'b0}}, i_den} << BIT;
        w_ge  = {{TW{1'b0}}, i_rem} >= w_shd;
        n_rem = w_ge ? (i_rem - w_shd[NB-1:0]) : i_rem;
        n_quo = i_quo;
        n_quo[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!i_stall) begin
            o_valid <= i_valid;
        end
        if (!i_stall) begin
            o_rem  <= n_rem;
            o_den  <= i_den;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

>>> hdl/cfpd_bcd_cell.sv
// One double-dabble cell: shifts one binary bit into two BCD registers.
`default_nettype none
module cfpd_bcd_cell #(
    parameter int DW = 28,
    parameter int FW = 30,
    parameter int VW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_stall,
    input  wire logic [FW-1:0] i_fbin,
    input  wire logic [FW-1:0] i_pbin,
    input  wire logic [DW-1:0] i_fbcd,
    input  wire logic [DW-1:0] i_pbcd,
    input  wire logic [VW-1:0] i_side,
    output logic               o_valid,
    output logic [FW-1:0]      o_fbin,
    output logic [FW-1:0]      o_pbin,
    output logic [DW-1:0]      o_fbcd,
    output logic [DW-1:0]      o_pbcd,
    output logic [VW-1:0]      o_side
);
    function automatic logic [DW-1:0] add3(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v;
        for (int k = 0; k < DW / 4; k++) begin
            if (r[4*k +: 4] >= 4'd5) begin
                r[4*k +: 4] = r[4*k +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    logic [DW-1:0] w_fa;
    logic [DW-1:0] w_pa;

    assign w_fa = add3(i_fbcd);
    assign w_pa = add3(i_pbcd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!i_stall) begin
            o_valid <= i_valid;
        end
        if (!i_stall) begin
            o_fbcd <= {w_fa[DW-2:0], i_fbin[FW-1]};
            o_pbcd <= {w_pa[DW-2:0], i_pbin[FW-1]};
            o_fbin <= {i_fbin[FW-2:0], 1'b0};
            o_pbin <= {i_pbin[FW-2:0], 1'b0};
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

>>> hdl/count_to_freq_and_period_digits_unit.sv
// Stages: one input stage, NUM_BITS divider cells, BW BCD cells and an output register, where
// BW is the larger of NUM_BITS and the total width (30 divider and 30 BCD cells at the defaults).
// Throughput: one request per cycle unless stalled; each cell retires one quotient or BCD bit.
// The whole chain advances together and holds when the output is stalled.
// Reset is synchronous, active low, and clears only the valid bits of the chain.
// There is no other state; payload registers are not reset.
`default_nettype none
`include "count_to_freq_and_period_digits_unit_macros.svh"
module count_to_freq_and_period_digits_unit #(
    parameter int DIGIT_COUNT    = 7,
    parameter int LOW_COUNT_BITS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [15:0]              i_overflow_count,
    input  wire logic [7:0]               i_residual_count,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [4*DIGIT_COUNT-1:0]      o_freq_bcd,
    output logic [DIGIT_COUNT-1:0]        o_freq_show_mask,
    output logic                          o_freq_overflow,
    output logic [4*DIGIT_COUNT-1:0]      o_period_bcd,
    output logic [DIGIT_COUNT-1:0]        o_period_show_mask,
    output logic                          o_period_unit,
    output logic                          o_zero_count
);
    import cfpd_pkg::*;

    // Total count width and the digit-limit value.
    localparam int TW = 16 + LOW_COUNT_BITS;
    localparam int DW = 4 * DIGIT_COUNT;
    localparam int NB = NUM_BITS;
    // The BCD chain must hold both the frequency and the quotient.
    localparam int BW = (TW > NB) ? TW : NB;
    localparam longint unsigned LIM = 64'(10) ** DIGIT_COUNT - 64'd1;
    localparam int VW = BW + 3;

    // The whole chain stalls as one when the output holds a request.
    logic w_stall;
    assign w_stall = o_valid && !i_ready;
    assign o_ready = !w_stall;

    // Input stage: form total, saturate frequency, choose the numerator.
    logic            r_v0;
    logic [NB-1:0]   r_num0;
    logic [TW-1:0]   r_den0;
    logic [BW-1:0]   r_fval0;
    t_flags          r_fl0;
    logic [TW-1:0]   w_total;
    logic [LOW_COUNT_BITS-1:0] w_res;

    always_comb begin
        w_res = LOW_COUNT_BITS'({8'd0, i_residual_count});
        w_total = {i_overflow_count, w_res};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (!w_stall) begin
            r_v0 <= i_valid;
        end
        if (!w_stall) begin
            r_den0 <= w_total;
            r_fl0.zero <= (w_total == '0);
            r_fl0.unit <= (64'(w_total) >= 64'(USEC_THRESHOLD));
            r_num0 <= (64'(w_total) >= 64'(USEC_THRESHOLD)) ? NB'(NSEC_NUMERATOR)
                                                             : NB'(USEC_NUMERATOR);
            if (64'(w_total) > LIM) begin
                r_fval0 <= BW'(LIM);
                r_fl0.fover <= 1'b1;
            end else begin
                r_fval0 <= BW'(w_total);
                r_fl0.fover <= 1'b0;
            end
        end
    end

    // Divider chain: cell k settles quotient bit NB-1-k. A zero divisor
    // gives an all-ones quotient, which is replaced after the chain.
    logic [NB:0]          dv_v;
    logic [NB-1:0]        dv_rem  [NB+1];
    logic [TW-1:0]        dv_den  [NB+1];
    logic [NB-1:0]        dv_quo  [NB+1];
    logic [VW-1:0]        dv_side [NB+1];

    assign dv_v[0]    = r_v0;
    assign dv_rem[0]  = r_num0;
    assign dv_den[0]  = r_den0;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = {r_fval0, r_fl0};

    for (genvar k = 0; k < NB; k++) begin : g_div
        cfpd_div_cell #(.TW(TW), .NB(NB), .BIT(NB - 1 - k), .VW(VW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(dv_v[k]), .i_stall(w_stall),
            .i_rem(dv_rem[k]), .i_den(dv_den[k]), .i_quo(dv_quo[k]),
            .i_side(dv_side[k]),
            .o_valid(dv_v[k+1]), .o_rem(dv_rem[k+1]), .o_den(dv_den[k+1]),
            .o_quo(dv_quo[k+1]), .o_side(dv_side[k+1])
        );
    end

    // Period saturation and zero replacement feed the BCD chain.
    t_flags        w_fl;
    logic [BW-1:0] w_fv;
    logic [NB-1:0] w_per;
    assign {w_fv, w_fl} = dv_side[NB];
    always_comb begin
        if (w_fl.zero) begin
            w_per = '0;
        end else if (64'(dv_quo[NB]) > LIM) begin
            w_per = NB'(LIM);
        end else begin
            w_per = dv_quo[NB];
        end
    end

    // Double-dabble chain, one binary bit per cell, both values side by side.
    logic [BW:0]   bc_v;
    logic [BW-1:0] bc_fb  [BW+1];
    logic [BW-1:0] bc_pb  [BW+1];
    logic [DW-1:0] bc_fd  [BW+1];
    logic [DW-1:0] bc_pd  [BW+1];
    logic [2:0]    bc_side[BW+1];

    assign bc_v[0]    = dv_v[NB];
    assign bc_fb[0]   = w_fv;
    assign bc_pb[0]   = BW'(w_per);
    assign bc_fd[0]   = '0;
    assign bc_pd[0]   = '0;
    assign bc_side[0] = w_fl;

    for (genvar k = 0; k < BW; k++) begin : g_bcd
        cfpd_bcd_cell #(.DW(DW), .FW(BW), .VW(3)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(bc_v[k]), .i_stall(w_stall),
            .i_fbin(bc_fb[k]), .i_pbin(bc_pb[k]), .i_fbcd(bc_fd[k]),
            .i_pbcd(bc_pd[k]), .i_side(bc_side[k]),
            .o_valid(bc_v[k+1]), .o_fbin(bc_fb[k+1]), .o_pbin(bc_pb[k+1]),
            .o_fbcd(bc_fd[k+1]), .o_pbcd(bc_pd[k+1]), .o_side(bc_side[k+1])
        );
    end

    // Leading-zero blanking: digit 0 always shows; each higher nonzero
    // digit lights every digit below it.
    function automatic logic [DIGIT_COUNT-1:0] show_mask(input logic [DW-1:0] b);
        logic [DIGIT_COUNT-1:0] m;
        logic                   seen;
        seen = 1'b0;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            seen = seen || (b[4*i +: 4] != 4'd0) || (i == 0);
            m[i] = seen;
        end
        return m;
    endfunction

    t_flags w_ofl;
    assign w_ofl = bc_side[BW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!w_stall) begin
            o_valid <= bc_v[BW];
        end
        if (!w_stall) begin
            o_freq_bcd         <= bc_fd[BW];
            o_freq_show_mask   <= show_mask(bc_fd[BW]);
            o_freq_overflow    <= w_ofl.fover;
            o_period_bcd       <= bc_pd[BW];
            o_period_show_mask <= show_mask(bc_pd[BW]);
            o_period_unit      <= w_ofl.unit;
            o_zero_count       <= w_ofl.zero;
        end
    end

    // A zero count never reports nanoseconds, and digit 0 is always shown.
    `CFP_ASSERT_IMPL(a_zero_unit, i_clk, i_rst_n, o_valid && o_zero_count, !o_period_unit)
    `CFP_ASSERT_IMPL(a_mask0, i_clk, i_rst_n, o_valid,
                     o_freq_show_mask[0] && o_period_show_mask[0])
    `CFP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
                     o_valid && $stable(o_period_bcd))
endmodule
`default_nettype wire
